@@ rtl/utq_pkg.sv @@
// Shared constants of the UART transmit queue: character codes, command codes and stream widths.
// No dependencies; imported by the top level of the queue.
package utq_pkg;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Input command codes carried in the input tuser.
    localparam logic CMD_PUT     = 1'b0;
    localparam logic CMD_TX_RDY  = 1'b1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int FILL_W      = 6;

endpackage

@@ rtl/uart_tx_queue_crlf.sv @@
// Top level of the UART transmit queue with line-feed to CR/LF expansion.
// Depends on utq_pkg (constants) and utq_ram (ring storage).
//
// This block is the transmit side queue of a UART. Each input transaction is either a put
// of one byte from software or a notice that the transmitter can take the next byte; the
// kind travels in the input tuser. A put stores its byte in a ring of DEPTH slots that holds
// at most DEPTH-1 bytes; a line feed is stored as a carriage return followed by the line
// feed, and each of the two bytes is checked for space on its own, so a ring with one free
// slot keeps the carriage return and drops the line feed. A byte that finds the ring full is
// dropped silently. Every stored byte turns the data-register-empty interrupt enable on. A
// transmitter-ready transaction pops the oldest byte and hands it out with send_valid set;
// on an empty ring it sends nothing and clears the interrupt enable. Every input transaction
// produces exactly one output transaction carrying send_valid, send_byte, bytes_stored,
// irq_enabled and fill_level (the byte count after the item, modulo 64). Bytes live in one
// synchronous RAM with a registered read port; the indices and the enable are flip-flops.
// An ordinary put and a pop on an empty ring go from idle straight to the output state;
// a line feed first passes a second write state (the two ring writes share the single
// write port) and a pop that finds a byte passes a read state for the registered RAM read. The
// output state waits while a stalled downstream holds the output register. The next item
// is taken once the previous result is in the output register, so a waiting result does
// not hold up the acceptance of the following item. The RAM content is undefined after
// reset; no clearing pass is needed, because a pop only reads slots that a put has written.
module uart_tx_queue_crlf #(
    parameter int DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [utq_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // [7:0] data_byte
    input  logic [0:0]                         i_s_tuser,  // [0] command
    // Output stream.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [7:0] send_byte, [9:8] bytes_stored, [10] irq_enabled, [16:11] fill_level, rest zero
    output logic [utq_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic [0:0]                         o_m_tuser   // [0] send_valid
);

    import utq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = (AW > FILL_W) ? AW : FILL_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LF   = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic          r_irq, n_irq;

    // Pending result of the item in flight.
    logic          r_res_valid, n_res_valid;
    logic [7:0]    r_res_byte, n_res_byte;
    logic [1:0]    r_res_stored, n_res_stored;

    // Output register.
    logic                   r_ovalid, n_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;
    logic                   r_ouser, n_ouser;

    logic          accept;
    logic          out_free;
    logic [AW-1:0] wr_next;
    logic [AW-1:0] rd_next;
    logic          ring_full;
    logic          ring_empty;
    logic          ram_we;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [7:0]    ram_rdata;
    logic [AW:0]   fill_diff;
    logic [AW-1:0] fill_cnt;
    logic [FW-1:0] fill_ext;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        if (p == AW'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign out_free   = !r_ovalid || i_m_tready;

    assign wr_next    = next_slot(r_wr);
    assign rd_next    = next_slot(r_rd);
    assign ring_full  = (wr_next == r_rd);
    assign ring_empty = (r_wr == r_rd);

    // Fill count, modulo DEPTH, then reduced to the reported width.
    assign fill_diff = {1'b0, r_wr} - {1'b0, r_rd};
    assign fill_cnt  = fill_diff[AW] ? AW'(fill_diff + (AW + 1)'(DEPTH)) : fill_diff[AW-1:0];
    assign fill_ext  = FW'(fill_cnt);

    utq_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_wr         = r_wr;
        n_rd         = r_rd;
        n_irq        = r_irq;
        n_res_valid  = r_res_valid;
        n_res_byte   = r_res_byte;
        n_res_stored = r_res_stored;
        n_ovalid     = r_ovalid;
        n_odata      = r_odata;
        n_ouser      = r_ouser;
        ram_we       = 1'b0;
        ram_wdata    = r_res_byte;
        ram_re       = 1'b0;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_valid  = 1'b0;
                    n_res_byte   = '0;
                    n_res_stored = '0;
                    if (i_s_tuser[0] == CMD_PUT) begin
                        // A line feed first stores a carriage return; the feed
                        // itself follows in the next cycle.
                        if (i_s_tdata == CHAR_LF) begin
                            ram_wdata  = CHAR_CR;
                            n_res_byte = CHAR_LF;
                            n_state    = S_LF;
                        end else begin
                            ram_wdata  = i_s_tdata;
                            n_state    = S_OUT;
                        end
                        if (!ring_full) begin
                            ram_we       = 1'b1;
                            n_wr         = wr_next;
                            n_irq        = 1'b1;
                            n_res_stored = 2'd1;
                        end
                    end else begin
                        if (!ring_empty) begin
                            ram_re  = 1'b1;
                            n_state = S_RD;
                        end else begin
                            n_irq   = 1'b0;
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_LF: begin
                ram_wdata  = CHAR_LF;
                n_res_byte = '0;
                if (!ring_full) begin
                    ram_we       = 1'b1;
                    n_wr         = wr_next;
                    n_irq        = 1'b1;
                    n_res_stored = r_res_stored + 2'd1;
                end
                n_state = S_OUT;
            end
            S_RD: begin
                n_res_valid = 1'b1;
                n_res_byte  = ram_rdata;
                n_rd        = rd_next;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ouser  = r_res_valid;
                    n_odata  = OUT_TDATA_W'({fill_ext[FILL_W-1:0], r_irq, r_res_stored,
                                             r_res_byte});
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr     <= '0;
            r_rd     <= '0;
            r_irq    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr     <= n_wr;
            r_rd     <= n_rd;
            r_irq    <= n_irq;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_valid  <= n_res_valid;
        r_res_byte   <= n_res_byte;
        r_res_stored <= n_res_stored;
        r_odata      <= n_odata;
        r_ouser      <= n_ouser;
    end

    assign o_m_tvalid   = r_ovalid;
    assign o_m_tdata    = r_odata;
    assign o_m_tuser[0] = r_ouser;

    // The ring indices always stay inside the ring.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr <= AW'(DEPTH - 1)) && (r_rd <= AW'(DEPTH - 1)))
        else $error("ring index out of range");

    // A RAM read is only waited on while the ring holds data.
    a_rd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_wr != r_rd))
        else $error("pop read issued on an empty ring");

    // A transmitter-ready transaction on an empty ring clears the interrupt enable.
    a_irq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_s_tuser[0] == CMD_TX_RDY) && ring_empty) |=> !r_irq)
        else $error("interrupt enable not cleared on empty pop");

    // A result that sends a byte never reports stored bytes.
    a_send_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[9:8] == 2'd0))
        else $error("send and store reported in one result");

endmodule

@@ rtl/utq_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; used for the byte ring of the UART transmit queue.
module utq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
